// ----- rtl/lcadc_pkg.sv -----
// Shared types, constants and register codes for the load cell ADC reader.
`timescale 1ns / 1ps
`default_nettype none

package lcadc_pkg;

   localparam int RAW_W        = 24;
   localparam int MAX_AVG_LOG2 = 4;
   localparam int SUM_W        = RAW_W + MAX_AVG_LOG2;
   localparam int RD_CNT_W     = MAX_AVG_LOG2 + 1;
   localparam int SHIFT_W      = $clog2(MAX_AVG_LOG2 + 1) > 0 ? $clog2(MAX_AVG_LOG2 + 1) : 1;
   localparam int BIT_CNT_W    = $clog2(RAW_W + 1);
   localparam int FRAC_W       = 8;
   localparam int WEIGHT_W     = 41;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   localparam logic [RAW_W-1:0] SIGN_FLIP   = 24'h800000;
   localparam logic [RAW_W-1:0] TARE_RESET  = 24'd8371500;
   localparam logic [RAW_W-1:0] SCALE_RESET = 24'd289;

   // gain codes
   localparam logic [1:0] GAIN_A128 = 2'd0;
   localparam logic [1:0] GAIN_B32  = 2'd1;
   localparam logic [1:0] GAIN_A64  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POWERED_DOWN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_SELECT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_LOG2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARE_OFFSET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIPROCAL_SCALE = 3'd4;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_BIT_HIGH,
      PH_BIT_LOW,
      PH_PULSE_HIGH,
      PH_PULSE_LOW
   } phase_type;

   typedef struct packed {
      logic             powered_down;
      logic [1:0]       gain_select;
      logic [2:0]       average_log2;
      logic [RAW_W-1:0] tare_offset;
      logic [RAW_W-1:0] reciprocal_scale;
   } cfg_type;

   typedef struct packed {
      logic             serial_clock;
      logic             sample_done;
      logic [RAW_W-1:0] raw_average;
   } seq_out_type;

endpackage

`default_nettype wire

// ----- rtl/lcadc_seq.sv -----
// Serial bit sequencer and read averaging for the load cell ADC reader.
`timescale 1ns / 1ps
`default_nettype none

module lcadc_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  data_line,
   input  wire lcadc_pkg::cfg_type    cfg,
   output lcadc_pkg::seq_out_type     seq_out
);

   lcadc_pkg::phase_type                 phase_ff, phase_in;
   logic [lcadc_pkg::BIT_CNT_W-1:0]      bit_count_ff, bit_count_in;
   logic [lcadc_pkg::RAW_W-1:0]          shift_ff, shift_in;
   logic [1:0]                           pulse_count_ff, pulse_count_in;
   logic [lcadc_pkg::RD_CNT_W-1:0]       read_count_ff, read_count_in;
   logic [lcadc_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [lcadc_pkg::RAW_W-1:0]          last_avg_ff, last_avg_in;

   logic [lcadc_pkg::BIT_CNT_W-1:0]      bit_next;
   logic [lcadc_pkg::RAW_W-1:0]          shift_next;
   logic [1:0]                           pulse_next;
   logic [1:0]                           pulses_needed;
   logic                                 pulse_end;
   logic [lcadc_pkg::SHIFT_W-1:0]        avg_shift;
   logic [lcadc_pkg::RD_CNT_W-1:0]       read_next;
   logic [lcadc_pkg::RD_CNT_W-1:0]       read_target;
   logic                                 avg_end;
   logic [lcadc_pkg::SUM_W-1:0]          sum_next;
   logic [lcadc_pkg::SUM_W-1:0]          sum_scaled;

   always_comb begin
      unique case (cfg.gain_select)
         lcadc_pkg::GAIN_B32: pulses_needed = 2'd2;
         lcadc_pkg::GAIN_A64: pulses_needed = 2'd3;
         default:             pulses_needed = 2'd1;
      endcase
   end

   assign avg_shift = (int'(cfg.average_log2) > lcadc_pkg::MAX_AVG_LOG2)
                    ? lcadc_pkg::SHIFT_W'(lcadc_pkg::MAX_AVG_LOG2)
                    : lcadc_pkg::SHIFT_W'(cfg.average_log2);

   assign bit_next    = bit_count_ff + lcadc_pkg::BIT_CNT_W'(1);
   assign shift_next  = {shift_ff[lcadc_pkg::RAW_W-2:0], data_line};
   assign pulse_next  = pulse_count_ff + 2'd1;
   assign pulse_end   = pulse_next >= pulses_needed;
   assign read_next   = read_count_ff + lcadc_pkg::RD_CNT_W'(1);
   assign read_target = lcadc_pkg::RD_CNT_W'(1) << avg_shift;
   assign avg_end     = read_next >= read_target;
   assign sum_next    = sum_ff + lcadc_pkg::SUM_W'(shift_ff);
   assign sum_scaled  = sum_next >> avg_shift;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      pulse_count_in = pulse_count_ff;
      read_count_in  = read_count_ff;
      sum_in         = sum_ff;
      last_avg_in    = last_avg_ff;
      if (cfg.powered_down) begin
         // abandon the read and the partial average
         phase_in       = lcadc_pkg::PH_WAIT;
         bit_count_in   = '0;
         shift_in       = '0;
         pulse_count_in = '0;
         read_count_in  = '0;
         sum_in         = '0;
      end else begin
         unique case (phase_ff)
            lcadc_pkg::PH_WAIT: begin
               if (!data_line) begin
                  bit_count_in = '0;
                  shift_in     = '0;
                  phase_in     = lcadc_pkg::PH_BIT_HIGH;
               end
            end
            lcadc_pkg::PH_BIT_HIGH: begin
               phase_in = lcadc_pkg::PH_BIT_LOW;
            end
            lcadc_pkg::PH_BIT_LOW: begin
               bit_count_in = bit_next;
               if (int'(bit_next) >= lcadc_pkg::RAW_W) begin
                  shift_in       = shift_next ^ lcadc_pkg::SIGN_FLIP;
                  pulse_count_in = '0;
                  phase_in       = lcadc_pkg::PH_PULSE_HIGH;
               end else begin
                  shift_in = shift_next;
                  phase_in = lcadc_pkg::PH_BIT_HIGH;
               end
            end
            lcadc_pkg::PH_PULSE_HIGH: begin
               phase_in = lcadc_pkg::PH_PULSE_LOW;
            end
            lcadc_pkg::PH_PULSE_LOW: begin
               pulse_count_in = pulse_next;
               if (pulse_end) begin
                  if (avg_end) begin
                     last_avg_in   = sum_scaled[lcadc_pkg::RAW_W-1:0];
                     read_count_in = '0;
                     sum_in        = '0;
                  end else begin
                     read_count_in = read_next;
                     sum_in        = sum_next;
                  end
                  phase_in       = lcadc_pkg::PH_WAIT;
                  bit_count_in   = '0;
                  shift_in       = '0;
                  pulse_count_in = '0;
               end else begin
                  phase_in = lcadc_pkg::PH_PULSE_HIGH;
               end
            end
            default: begin
               phase_in       = lcadc_pkg::PH_WAIT;
               bit_count_in   = '0;
               shift_in       = '0;
               pulse_count_in = '0;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      seq_out.serial_clock = 1'b0;
      seq_out.sample_done  = 1'b0;
      seq_out.raw_average  = last_avg_in;
      if (cfg.powered_down) begin
         seq_out.serial_clock = 1'b1;
      end else begin
         unique case (phase_ff)
            lcadc_pkg::PH_BIT_HIGH,
            lcadc_pkg::PH_PULSE_HIGH: seq_out.serial_clock = 1'b1;
            lcadc_pkg::PH_PULSE_LOW:  seq_out.sample_done  = pulse_end && avg_end;
            default:                  seq_out.serial_clock = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= lcadc_pkg::PH_WAIT;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         pulse_count_ff <= '0;
         read_count_ff  <= '0;
         sum_ff         <= '0;
         last_avg_ff    <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         pulse_count_ff <= pulse_count_in;
         read_count_ff  <= read_count_in;
         sum_ff         <= sum_in;
         last_avg_ff    <= last_avg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lcadc_weight.sv -----
// Tare subtraction and reciprocal scaling into a Q.8 weight, two stages.
`timescale 1ns / 1ps
`default_nettype none

module lcadc_weight (
   input  wire logic                                clock,
   input  wire logic                                load_diff,
   input  wire logic                                load_prod,
   input  wire logic [lcadc_pkg::RAW_W-1:0]         raw_average,
   input  wire logic [lcadc_pkg::RAW_W-1:0]         tare_offset,
   input  wire logic [lcadc_pkg::RAW_W-1:0]         reciprocal_scale,
   output logic signed [lcadc_pkg::WEIGHT_W-1:0]    weight_q8
);

   logic signed [lcadc_pkg::RAW_W:0]       diff_ff, diff_in;
   logic signed [2*lcadc_pkg::RAW_W+1:0]   product;
   logic signed [lcadc_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;

   assign diff_in   = $signed({1'b0, raw_average}) - $signed({1'b0, tare_offset});
   assign product   = (2*lcadc_pkg::RAW_W+2)'(diff_ff)
                    * (2*lcadc_pkg::RAW_W+2)'($signed({1'b0, reciprocal_scale}));
   // arithmetic drop of the fraction rounds toward minus infinity
   assign weight_in = product[lcadc_pkg::FRAC_W +: lcadc_pkg::WEIGHT_W];
   assign weight_q8 = weight_ff;

   always_ff @(posedge clock) begin
      if (load_diff) begin
         diff_ff <= diff_in;
      end
      if (load_prod) begin
         weight_ff <= weight_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/load_cell_adc_reader_unit.sv -----
// Load cell ADC reader top level: register file, tick pipeline and result handshake.
// An accepted tick word moves through the s1, s2 and s3 registers to rsp_valid.
// Throughput: one tick word per cycle; three pipeline stages (sequencer update,
// tare subtract, scale multiply) advance together unless the result side stalls.
// Reset: synchronous, active high; clears the sequencer, the averaging state and
// stage valids, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_adc_reader_unit (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic                                      req_data_line,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic                                           rsp_serial_clock,
   output logic                                           rsp_sample_done,
   output logic [lcadc_pkg::RAW_W-1:0]                    rsp_raw_average,
   output logic signed [lcadc_pkg::WEIGHT_W-1:0]          rsp_weight_q8,
   input  wire logic                                      csr_write_enable,
   input  wire logic [lcadc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [lcadc_pkg::CSR_DATA_W-1:0]          csr_write_data
);

   lcadc_pkg::cfg_type      cfg_ff;
   lcadc_pkg::seq_out_type  seq_out;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s3_valid_ff, s3_valid_in;
   lcadc_pkg::seq_out_type  s1_ff, s2_ff, s3_ff;

   logic                    accept;
   logic                    adv2, adv3;
   logic                    s2_free, s3_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.powered_down     <= 1'b0;
         cfg_ff.gain_select      <= lcadc_pkg::GAIN_A64;
         cfg_ff.average_log2     <= 3'd0;
         cfg_ff.tare_offset      <= lcadc_pkg::TARE_RESET;
         cfg_ff.reciprocal_scale <= lcadc_pkg::SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lcadc_pkg::CSR_POWERED_DOWN:     cfg_ff.powered_down     <= csr_write_data[0];
            lcadc_pkg::CSR_GAIN_SELECT:      cfg_ff.gain_select      <= csr_write_data[1:0];
            lcadc_pkg::CSR_AVERAGE_LOG2:     cfg_ff.average_log2     <= csr_write_data[2:0];
            lcadc_pkg::CSR_TARE_OFFSET:      cfg_ff.tare_offset      <= csr_write_data;
            lcadc_pkg::CSR_RECIPROCAL_SCALE: cfg_ff.reciprocal_scale <= csr_write_data;
            default:                         cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // pipeline advance: a stage moves when the one after it is empty or moving
   assign s3_free   = !s3_valid_ff || rsp_ready;
   assign adv3      = s2_valid_ff && s3_free;
   assign s2_free   = !s2_valid_ff || adv3;
   assign adv2      = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || adv2;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in = accept ? 1'b1 : (adv2 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = adv2 ? 1'b1 : (adv3 ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = adv3 ? 1'b1 : (rsp_ready ? 1'b0 : s3_valid_ff);

   lcadc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .data_line (req_data_line),
      .cfg       (cfg_ff),
      .seq_out   (seq_out)
   );

   lcadc_weight u_weight (
      .clock            (clock),
      .load_diff        (adv2),
      .load_prod        (adv3),
      .raw_average      (s1_ff.raw_average),
      .tare_offset      (cfg_ff.tare_offset),
      .reciprocal_scale (cfg_ff.reciprocal_scale),
      .weight_q8        (rsp_weight_q8)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= seq_out;
      end
      if (adv2) begin
         s2_ff <= s1_ff;
      end
      if (adv3) begin
         s3_ff <= s2_ff;
      end
   end

   assign rsp_valid        = s3_valid_ff;
   assign rsp_serial_clock = s3_ff.serial_clock;
   assign rsp_sample_done  = s3_ff.sample_done;
   assign rsp_raw_average  = s3_ff.raw_average;

endmodule

`default_nettype wire

// ----- rtl/lcadc_checker.sv -----
// Port-level checks for the load cell ADC reader, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcadc_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_ready,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic                                rsp_serial_clock,
   input  wire logic                                rsp_sample_done,
   input  wire logic [lcadc_pkg::RAW_W-1:0]         rsp_raw_average,
   input  wire logic signed [lcadc_pkg::WEIGHT_W-1:0] rsp_weight_q8
);

   // a finished average lands on a low-clock tick
   a_done_on_low_clock: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_done) |-> !rsp_serial_clock)
      else $error("sample_done with serial clock high");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // with the output slot free, the pipeline always drains enough to take a word
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while result side is free");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_raw_average)
                                     && $stable(rsp_weight_q8)))
      else $error("stalled result word changed");

endmodule

bind load_cell_adc_reader_unit lcadc_checker u_lcadc_checker (.*);

`default_nettype wire

// ----- dv/tb_load_cell_adc_reader_unit.sv -----
// Self-checking testbench for the load cell ADC reader: tick stream in, per-tick result out.
`timescale 1ns / 1ps

module tb_load_cell_adc_reader_unit;
   import lcadc_pkg::*;

   localparam int         STALL_LIMIT   = 2000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         FULL_READING  = 1000;
   localparam int         STALL_NONE    = 0;
   localparam int         STALL_RANDOM  = 1;
   localparam int         STALL_PATTERN = 2;
   localparam logic [1:0] GAIN_UNUSED   = 2'd3;

   typedef struct packed {
      seq_out_type                 seq;
      logic signed [WEIGHT_W-1:0]  weight;
   } tick_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_data_line = 1'b1;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_serial_clock;
   logic                          rsp_sample_done;
   logic [RAW_W-1:0]              rsp_raw_average;
   logic signed [WEIGHT_W-1:0]    rsp_weight_q8;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_write_data = '0;

   // converter-side model state
   cfg_type                       cfg;
   phase_type                     conv_phase = PH_WAIT;
   logic [BIT_CNT_W-1:0]          conv_bits = '0;
   logic [RAW_W-1:0]              conv_shift = '0;
   logic [1:0]                    conv_pulses = '0;
   logic [RD_CNT_W-1:0]           conv_reads = '0;
   logic [SUM_W-1:0]              conv_sum = '0;
   logic [RAW_W-1:0]              conv_last_avg = '0;

   tick_result_type               expected_ticks[$];
   int                            error_count = 0;
   int                            burst_left = 0;
   bit                            gaps_on = 1'b0;
   int                            hold_request = 0;

   load_cell_adc_reader_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_line    (req_data_line),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_sample_done  (rsp_sample_done),
      .rsp_raw_average  (rsp_raw_average),
      .rsp_weight_q8    (rsp_weight_q8),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pulses_for_gain(input logic [1:0] gain);
      case (gain)
         GAIN_B32: return 2;
         GAIN_A64: return 3;
         default:  return 1;
      endcase
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] weight_of_average(input logic [RAW_W-1:0] raw);
      longint diff;
      longint prod;
      diff = longint'(raw) - longint'(cfg.tare_offset);
      prod = diff * longint'(cfg.reciprocal_scale);
      prod = prod >>> FRAC_W;
      return prod[WEIGHT_W-1:0];
   endfunction

   function automatic logic [RAW_W-1:0] pick_code();
      case ($urandom_range(0, 7))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return 24'h7FFFFF;
         3:       return 24'h800000;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   task automatic clear_conversion();
      conv_phase  = PH_WAIT;
      conv_bits   = '0;
      conv_shift  = '0;
      conv_pulses = '0;
   endtask

   // advance the converter model by one tick and queue the word it should produce
   task automatic step_converter(input logic data);
      tick_result_type  res;
      logic             clk_level;
      logic             done;
      int               sh;
      logic [SUM_W-1:0] avg_full;
      clk_level = 1'b0;
      done      = 1'b0;
      if (cfg.powered_down) begin
         clk_level = 1'b1;
         clear_conversion();
         conv_reads = '0;
         conv_sum   = '0;
      end else begin
         case (conv_phase)
            PH_WAIT: begin
               if (!data) begin
                  conv_bits  = '0;
                  conv_shift = '0;
                  conv_phase = PH_BIT_HIGH;
               end
            end
            PH_BIT_HIGH: begin
               clk_level  = 1'b1;
               conv_phase = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               conv_shift = {conv_shift[RAW_W-2:0], data};
               conv_bits  = conv_bits + BIT_CNT_W'(1);
               if (int'(conv_bits) >= RAW_W) begin
                  conv_shift  = conv_shift ^ SIGN_FLIP;
                  conv_pulses = '0;
                  conv_phase  = PH_PULSE_HIGH;
               end else begin
                  conv_phase = PH_BIT_HIGH;
               end
            end
            PH_PULSE_HIGH: begin
               clk_level  = 1'b1;
               conv_phase = PH_PULSE_LOW;
            end
            PH_PULSE_LOW: begin
               conv_pulses = conv_pulses + 2'd1;
               if (int'(conv_pulses) >= pulses_for_gain(cfg.gain_select)) begin
                  sh = (int'(cfg.average_log2) > MAX_AVG_LOG2) ? MAX_AVG_LOG2
                                                                : int'(cfg.average_log2);
                  conv_sum   = conv_sum + SUM_W'(conv_shift);
                  conv_reads = conv_reads + RD_CNT_W'(1);
                  if (int'(conv_reads) >= (1 << sh)) begin
                     avg_full      = conv_sum >> sh;
                     conv_last_avg = avg_full[RAW_W-1:0];
                     done          = 1'b1;
                     conv_reads    = '0;
                     conv_sum      = '0;
                  end
                  clear_conversion();
               end else begin
                  conv_phase = PH_PULSE_HIGH;
               end
            end
            default: clear_conversion();
         endcase
      end
      res.seq.serial_clock = clk_level;
      res.seq.sample_done  = done;
      res.seq.raw_average  = conv_last_avg;
      res.weight           = weight_of_average(conv_last_avg);
      expected_ticks.push_back(res);
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_POWERED_DOWN:     cfg.powered_down     = value[0];
         CSR_GAIN_SELECT:      cfg.gain_select      = value[1:0];
         CSR_AVERAGE_LOG2:     cfg.average_log2     = value[2:0];
         CSR_TARE_OFFSET:      cfg.tare_offset      = value;
         CSR_RECIPROCAL_SCALE: cfg.reciprocal_scale = value;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // registers change only with the pipeline empty
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      apply_register(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_tick(input logic data);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid     <= 1'b1;
      req_data_line <= data;
      do @(posedge clock); while (!req_ready);
      step_converter(data);
   endtask

   task automatic apply_settings(input logic [1:0] gain, input logic [2:0] avg_log2,
                                 input logic [RAW_W-1:0] tare, input logic [RAW_W-1:0] scale);
      drain_results();
      write_reg(CSR_GAIN_SELECT, CSR_DATA_W'(gain));
      write_reg(CSR_AVERAGE_LOG2, CSR_DATA_W'(avg_log2));
      write_reg(CSR_TARE_OFFSET, tare);
      write_reg(CSR_RECIPROCAL_SCALE, scale);
   endtask

   // one conversion from the wait phase; cut stops it that many ticks after the start
   task automatic send_reading(input logic [RAW_W-1:0] code, input int idle_ticks, input int cut);
      int sent;
      sent = 0;
      repeat (idle_ticks) send_tick(1'b1);
      send_tick(1'b0);
      for (int b = RAW_W - 1; b >= 0 && sent < cut; b--) begin
         send_tick(1'($urandom_range(0, 1)));
         send_tick(code[b]);
         sent += 2;
      end
      while (sent < cut && (conv_phase == PH_PULSE_HIGH || conv_phase == PH_PULSE_LOW)) begin
         send_tick(1'($urandom_range(0, 1)));
         sent++;
      end
   endtask

   task automatic finish_reading();
      while (conv_phase != PH_WAIT) send_tick(1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed();
      gaps_on = 1'b0;
      for (int i = CSR_RECIPROCAL_SCALE + 1; i < 2 ** CSR_IDX_W; i++) begin
         write_reg(CSR_IDX_W'(i), 24'hFFFFFF);
      end
      repeat (3) send_tick(1'b1);
      write_reg(CSR_POWERED_DOWN, 24'd1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      write_reg(CSR_POWERED_DOWN, 24'd0);
      send_tick(1'b0);
      for (int i = 0; i < 8; i++) send_tick(i[0]);
      // abandon the read after four bits
      drain_results();
      write_reg(CSR_POWERED_DOWN, 24'd1);
      send_tick(1'b1);
      send_tick(1'b0);
      write_reg(CSR_POWERED_DOWN, 24'd0);
      repeat (2) send_tick(1'b1);
   endtask

   task automatic test_settings_sweep();
      logic [RAW_W-1:0] code;
      for (int s = 0; s < 5; s++) begin
         case (s)
            0: apply_settings(GAIN_A128, 3'd0, 24'h000000, 24'hFFFFFF);
            1: apply_settings(GAIN_B32, 3'd0, 24'hFFFFFF, 24'hFFFFFF);
            2: apply_settings(GAIN_A64, 3'd2, RAW_W'($urandom), RAW_W'($urandom));
            3: apply_settings(GAIN_UNUSED, 3'd1, SIGN_FLIP, 24'h000000);
            default: apply_settings(2'($urandom_range(0, 3)), 3'($urandom_range(0, 3)),
                                    RAW_W'($urandom), RAW_W'($urandom_range(0, 4095)));
         endcase
         for (int k = 0; k < 2; k++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (k == 0) code = (s % 2 == 0) ? 24'h7FFFFF : 24'h800000;
            else code = pick_code();
            send_reading(code, $urandom_range(0, 4), FULL_READING);
         end
         // noise may start a stray read; run it out
         repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
         finish_reading();
      end
   endtask

   task automatic test_mid_read_writes();
      apply_settings(GAIN_A64, 3'd0, RAW_W'($urandom), RAW_W'($urandom));
      gaps_on = 1'b1;
      send_reading(pick_code(), 1, 50);
      drain_results();
      write_reg(CSR_GAIN_SELECT, CSR_DATA_W'(GAIN_A128));
      finish_reading();
      send_reading(pick_code(), 0, $urandom_range(1, 47));
      drain_results();
      write_reg(CSR_TARE_OFFSET, CSR_DATA_W'($urandom));
      write_reg(CSR_RECIPROCAL_SCALE, CSR_DATA_W'($urandom));
      finish_reading();
      // shorten the average while reads are pending
      apply_settings(GAIN_B32, 3'd2, RAW_W'($urandom), RAW_W'($urandom));
      repeat (2) send_reading(pick_code(), $urandom_range(0, 3), FULL_READING);
      drain_results();
      write_reg(CSR_AVERAGE_LOG2, 24'd0);
      send_reading(pick_code(), 0, FULL_READING);
      send_reading(pick_code(), 0, $urandom_range(5, 45));
      drain_results();
      write_reg(CSR_POWERED_DOWN, 24'd1);
      repeat (3) send_tick(1'($urandom_range(0, 1)));
      write_reg(CSR_POWERED_DOWN, 24'd0);
      send_reading(pick_code(), 2, FULL_READING);
   endtask

   task automatic test_large_average();
      apply_settings(GAIN_A128, 3'd7, RAW_W'($urandom), RAW_W'($urandom));
      gaps_on = 1'b1;
      repeat (16) send_reading(pick_code(), 0, FULL_READING);
   endtask

   task automatic test_backpressure();
      apply_settings(GAIN_A128, 3'd0, RAW_W'($urandom), RAW_W'($urandom));
      gaps_on      = 1'b0;
      hold_request = HOLD_CYCLES;
      send_reading(pick_code(), 0, FULL_READING);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result side: stall pattern, with a long hold when a test asks for one
   initial begin
      int          mode;
      int          mode_left;
      int          hold_left;
      logic [15:0] pat;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      pat       = 16'h0001;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(STALL_NONE, STALL_PATTERN);
               mode_left = $urandom_range(40, 300);
               pat       = 16'($urandom) | 16'h0001;
            end
            mode_left--;
            case (mode)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_ready <= pat[0];
                  pat = {pat[0], pat[15:1]};
               end
            endcase
         end
      end
   end

   initial begin
      tick_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_ticks.size() == 0) begin
               report_mismatch("word with none pending", 64'(rsp_raw_average), '0);
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_serial_clock !== want.seq.serial_clock)
                  report_mismatch("serial_clock", 64'(rsp_serial_clock),
                                  64'(want.seq.serial_clock));
               if (rsp_sample_done !== want.seq.sample_done)
                  report_mismatch("sample_done", 64'(rsp_sample_done),
                                  64'(want.seq.sample_done));
               if (rsp_raw_average !== want.seq.raw_average)
                  report_mismatch("raw_average", 64'(rsp_raw_average),
                                  64'(want.seq.raw_average));
               if (rsp_weight_q8 !== want.weight)
                  report_mismatch("weight_q8", 64'(rsp_weight_q8), 64'(want.weight));
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      cfg.powered_down     = 1'b0;
      cfg.gain_select      = GAIN_A64;
      cfg.average_log2     = 3'd0;
      cfg.tare_offset      = TARE_RESET;
      cfg.reciprocal_scale = SCALE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_settings_sweep();
      test_mid_read_writes();
      test_large_average();
      test_backpressure();
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
